FILE: hw/rtl/b2b_pkg.sv
`default_nettype none
package b2b_pkg;
   localparam int BLOCK_BYTES = 128;
   localparam int WORDS = BLOCK_BYTES / 8;
   localparam logic [63:0] PARAM_BASE = 64'h0000_0000_0101_0000;

   localparam logic [1:0] REG_DIGEST = 2'd0;
   localparam logic [1:0] REG_KEY = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_INGEST, ST_INIT, ST_MIX, ST_FOLD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic final_blk;
      logic done;
   } crunch_ctl_type;

   function automatic logic [63:0] iv(input logic [2:0] i);
      logic [63:0] r;
      case (i)
         3'd0: r = 64'h6A09E667F3BCC908;
         3'd1: r = 64'hBB67AE8584CAA73B;
         3'd2: r = 64'h3C6EF372FE94F82B;
         3'd3: r = 64'hA54FF53A5F1D36F1;
         3'd4: r = 64'h510E527FADE682D1;
         3'd5: r = 64'h9B05688C2B3E6C1F;
         3'd6: r = 64'h1F83D9ABFB41BD6B;
         default: r = 64'h5BE0CD19137E2179;
      endcase
      return r;
   endfunction

   function automatic logic [3:0] sigma(input logic [3:0] r, input logic [3:0] k);
      logic [63:0] row;
      case (r)
         4'd0, 4'd10: row = 64'hFEDCBA9876543210;
         4'd1, 4'd11: row = 64'h357B20C16DF984AE;
         4'd2: row = 64'h491763EADF250C8B;
         4'd3: row = 64'h8F04A562EBCD1397;
         4'd4: row = 64'hD386CB1EFA427509;
         4'd5: row = 64'h91EF57D438B0A6C2;
         4'd6: row = 64'hB8293670A4DEF15C;
         4'd7: row = 64'hA2684F05931CE7BD;
         4'd8: row = 64'h5A417D2C803B9EF6;
         default: row = 64'h0DC3E9BF5167482A;
      endcase
      return row[k*4 +: 4];
   endfunction

   function automatic logic [63:0] rotr(input logic [63:0] x, input logic [5:0] n);
      return (x >> n) | (x << (7'd64 - {1'b0, n}));
   endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/b2b_crunch.sv
`default_nettype none
module b2b_crunch
   import b2b_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire crunch_ctl_type ctl_in,
   output crunch_ctl_type      ctl_out,
   input  wire logic [63:0]    msg [WORDS],
   input  wire logic [63:0]    cnt_lo,
   input  wire logic [63:0]    cnt_hi,
   input  wire logic [63:0]    h_in [8],
   output logic [63:0]         h_out [8]
);
   logic [63:0] v_ff [16];
   logic [3:0]  round_ff;
   logic [2:0]  step_ff;
   logic        half_ff;
   logic        busy_ff;
   logic        done_ff;

   logic [3:0] ia, ib, ic, id;
   logic [63:0] a1, d1, c1, b1, mx;
   logic [2:0] g;

   assign g = step_ff;

   always_comb begin
      case (g)
         3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
         3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
         3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
         3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
         3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
         3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
         3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
         default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
      endcase
      mx = msg[sigma(round_ff, {g, half_ff})];
      a1 = v_ff[ia] + v_ff[ib] + mx;
      d1 = rotr(v_ff[id] ^ a1, half_ff ? 6'd16 : 6'd32);
      c1 = v_ff[ic] + d1;
      b1 = rotr(v_ff[ib] ^ c1, half_ff ? 6'd63 : 6'd24);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
         step_ff  <= '0;
         half_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl_in.start) begin
            busy_ff  <= 1'b1;
            round_ff <= '0;
            step_ff  <= '0;
            half_ff  <= 1'b0;
            for (int i = 0; i < 8; i++) begin
               v_ff[i]   <= h_in[i];
               v_ff[i+8] <= iv(3'(i));
            end
            v_ff[12] <= iv(3'd4) ^ cnt_lo;
            v_ff[13] <= iv(3'd5) ^ cnt_hi;
            v_ff[14] <= ctl_in.final_blk ? ~iv(3'd6) : iv(3'd6);
         end else if (busy_ff) begin
            v_ff[ia] <= a1;
            v_ff[ib] <= b1;
            v_ff[ic] <= c1;
            v_ff[id] <= d1;
            half_ff  <= ~half_ff;
            if (half_ff) begin
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd7) begin
                  round_ff <= round_ff + 4'd1;
                  if (round_ff == 4'd11) begin
                     busy_ff <= 1'b0;
                     done_ff <= 1'b1;
                  end
               end
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 8; i++) h_out[i] = h_in[i] ^ v_ff[i] ^ v_ff[i+8];
      ctl_out.start     = 1'b0;
      ctl_out.final_blk = 1'b0;
      ctl_out.done      = done_ff;
   end

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff);
   assert property (@(posedge clock) disable iff (reset) ctl_in.start |=> busy_ff);
   assert property (@(posedge clock) disable iff (reset) !busy_ff |=> step_ff == $past(step_ff)
      || $past(ctl_in.start));
endmodule
`default_nettype wire

FILE: hw/rtl/blake2b_hash_engine.sv
`default_nettype none
// BLAKE2b hash engine, optionally keyed.
// req_ channel: one transaction carries up to eight little-endian bytes,
// key bytes first (req_is_key), then message bytes; req_last ends a run.
// rsp_ channel: on a last transaction, ceil(digest_bytes/8) digest words, with
// digest_bytes clamped to 1..64, are sent, the final one with rsp_last_word set.
// csr_ port: register 0 digest_bytes at 0x0, register 1 key_bytes at 0x4.
// Flow: a plain transaction is captured in idle, its bytes are buffered
// one by one in ingest, and the engine returns to idle. A byte that
// arrives while the block buffer is full first runs one compression
// (setup, 192 half G steps on the single G unit, 12 rounds of 8 G steps,
// a registered done flag, and fold). A last transaction adds the final
// compression, then one digest word per cycle while rsp_ready is high;
// a stall holds the current word. req_ready is low during all of this.
// Reset clears the run; the configuration returns to 64 and 0 and the
// next transaction starts a fresh run.
module blake2b_hash_engine
   import b2b_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [63:0] req_data_word,
   input  wire logic [3:0]  req_byte_count,
   input  wire logic        req_is_key,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [63:0]      rsp_digest_word,
   output logic [3:0]       rsp_digest_count,
   output logic             rsp_last_word,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   localparam int BLOCK_SIZE = BLOCK_BYTES;
   localparam int FW = $clog2(BLOCK_SIZE + 1);
   localparam int NW = WORDS;

   state_type state_ff, state_in;
   logic [6:0]  dig_ff, key_ff;
   logic [63:0] buf_ff [NW];
   logic [63:0] h_ff [8];
   logic [63:0] cnt_lo_ff, cnt_hi_ff;
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] kfill_ff;
   logic        kpad_ff;
   logic [FW-1:0] lim;
   logic        run_ff, msg_ff;
   logic [63:0] data_ff;
   logic [3:0]  bc_ff, bi_ff;
   logic        key_item_ff, last_item_ff, final_ff;
   logic [2:0]  word_ff;
   crunch_ctl_type cin, cout;
   logic [63:0] h_new [8];
   logic [63:0] msg_pad [WORDS];
   logic [6:0]  olen;
   logic        wr;

   assign olen = (dig_ff == 7'd0) ? 7'd1 : (dig_ff > 7'd64 ? 7'd64 : dig_ff);
   assign wr = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   always_comb begin
      case (csr_paddr[2])
         1'b0: csr_prdata = {25'd0, dig_ff};
         default: csr_prdata = {25'd0, key_ff};
      endcase
   end

   assign lim = kpad_ff ? kfill_ff : fill_ff;

   always_comb begin
      for (int w = 0; w < WORDS; w++) begin
         for (int b = 0; b < 8; b++) begin
            msg_pad[w][b*8 +: 8] = ((w*8 + b) < int'(lim)) ? buf_ff[w][b*8 +: 8] : 8'd0;
         end
      end
   end

   b2b_crunch u_crunch (
      .clock(clock), .reset(reset), .ctl_in(cin), .ctl_out(cout),
      .msg(msg_pad), .cnt_lo(cnt_lo_ff), .cnt_hi(cnt_hi_ff),
      .h_in(h_ff), .h_out(h_new)
   );

   logic more_bytes, need_crunch, key_take;
   assign more_bytes  = bi_ff < bc_ff;
   assign need_crunch = !key_item_ff && msg_ff && (int'(fill_ff) >= BLOCK_SIZE);
   assign key_take = key_item_ff && !msg_ff && ({1'b0, fill_ff} < {1'b0, key_ff})
                     && (int'(fill_ff) < BLOCK_SIZE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_INGEST;
         ST_INGEST: begin
            if (more_bytes) begin
               if (need_crunch) state_in = ST_INIT;
            end else if (last_item_ff) state_in = ST_INIT;
            else state_in = ST_IDLE;
         end
         ST_INIT:   state_in = ST_MIX;
         ST_MIX:    if (cout.done) state_in = ST_FOLD;
         ST_FOLD:   state_in = final_ff ? ST_EMIT : ST_INGEST;
         ST_EMIT:   if (rsp_ready && word_ff == 3'((olen - 7'd1) >> 3)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_EMIT);
      cin.start = (state_ff == ST_INIT);
      cin.final_blk = final_ff;
      cin.done = 1'b0;
   end

   logic [6:0] left;
   assign left = olen - {1'b0, word_ff, 3'b000};
   always_comb begin
      rsp_digest_count = (left > 7'd8) ? 4'd8 : left[3:0];
      rsp_digest_word = h_ff[word_ff];
      for (int b = 0; b < 8; b++)
         if (b >= int'(rsp_digest_count)) rsp_digest_word[b*8 +: 8] = 8'd0;
      rsp_last_word = (word_ff == 3'((olen - 7'd1) >> 3));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         dig_ff <= 7'd64;
         key_ff <= 7'd0;
         run_ff <= 1'b0;
         msg_ff <= 1'b0;
         fill_ff <= '0;
         kfill_ff <= '0;
         kpad_ff <= 1'b0;
         final_ff <= 1'b0;
         word_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (wr) begin
            if (csr_paddr[2:2] == REG_DIGEST[0:0]) dig_ff <= csr_pwdata[6:0];
            else if (csr_paddr[2:2] == REG_KEY[0:0]) key_ff <= csr_pwdata[6:0];
         end
         case (state_ff)
            ST_IDLE: if (req_valid) begin
               data_ff <= req_data_word;
               bc_ff <= (req_byte_count > 4'd8) ? 4'd8 : req_byte_count;
               bi_ff <= '0;
               key_item_ff <= req_is_key;
               last_item_ff <= req_last;
               final_ff <= 1'b0;
               word_ff <= '0;
               if (!run_ff) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= iv(3'(i));
                  h_ff[0] <= iv(3'd0) ^ PARAM_BASE ^ {49'd0, key_ff, 8'd0} ^ {57'd0, olen};
                  cnt_lo_ff <= '0;
                  cnt_hi_ff <= '0;
                  fill_ff <= '0;
                  kpad_ff <= 1'b0;
                  msg_ff <= 1'b0;
                  run_ff <= 1'b1;
               end
               if (!req_is_key && (run_ff ? !msg_ff : 1'b1)) begin
                  msg_ff <= 1'b1;
                  if (key_ff != 7'd0) begin
                     fill_ff <= FW'(BLOCK_SIZE);
                     kfill_ff <= run_ff ? fill_ff : '0;
                     kpad_ff <= 1'b1;
                  end
               end
            end
            ST_INGEST: begin
               if (more_bytes) begin
                  if (need_crunch) begin
                     {cnt_hi_ff, cnt_lo_ff} <= {cnt_hi_ff, cnt_lo_ff} + 128'(BLOCK_SIZE);
                  end else begin
                     if (!key_item_ff || key_take) begin
                        buf_ff[fill_ff[FW-2:3]][fill_ff[2:0]*8 +: 8] <= data_ff[bi_ff[2:0]*8 +: 8];
                        fill_ff <= fill_ff + 1'b1;
                     end
                     bi_ff <= bi_ff + 4'd1;
                  end
               end else if (last_item_ff) begin
                  if (!msg_ff) begin
                     msg_ff <= 1'b1;
                     if (key_ff != 7'd0) begin
                        fill_ff <= FW'(BLOCK_SIZE);
                        kfill_ff <= fill_ff;
                        kpad_ff <= 1'b1;
                        {cnt_hi_ff, cnt_lo_ff} <= {cnt_hi_ff, cnt_lo_ff} + 128'(BLOCK_SIZE);
                     end
                  end else begin
                     {cnt_hi_ff, cnt_lo_ff} <= {cnt_hi_ff, cnt_lo_ff} + 128'(fill_ff);
                  end
                  final_ff <= 1'b1;
               end
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_new[i];
               kpad_ff <= 1'b0;
               if (!final_ff) fill_ff <= '0;
            end
            ST_EMIT: if (rsp_ready) begin
               word_ff <= word_ff + 3'd1;
               if (rsp_last_word) begin
                  run_ff <= 1'b0;
                  msg_ff <= 1'b0;
                  fill_ff <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(req_ready && rsp_valid));
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> req_ready);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_count != 4'd0));
endmodule
`default_nettype wire
